// File: rtl/core/pva_pkg.sv
// Shared types and codes for the polyphonic voice allocator.
// No dependencies; used by every module under rtl/core.
package pva_pkg;

	localparam int NUM_VOICES_DEF   = 16;
	localparam int NUM_CHANNELS_DEF = 16;
	localparam int AGE_BITS_DEF     = 8;

	// input function codes
	localparam logic [2:0] FUNC_NOTE_ON     = 3'd0;
	localparam logic [2:0] FUNC_NOTE_OFF    = 3'd1;
	localparam logic [2:0] FUNC_SET_HOLD    = 3'd2;
	localparam logic [2:0] FUNC_TICK        = 3'd3;
	localparam logic [2:0] FUNC_ALL_KEY_OFF = 3'd4;
	localparam logic [2:0] FUNC_ALL_MUTE    = 3'd5;

	// operations handed from front to back
	typedef enum logic [2:0] {
		OP_NOTE_ON  = 3'd0,
		OP_NOTE_OFF = 3'd1,
		OP_RELEASE  = 3'd2,
		OP_TICK     = 3'd3,
		OP_ALL_OFF  = 3'd4,
		OP_ALL_MUTE = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ACT_KEY_ON      = 2'd0,
		ACT_KEY_OFF     = 2'd1,
		ACT_ALL_KEY_OFF = 2'd2,
		ACT_ALL_MUTE    = 2'd3
	} act_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] channel;
		logic [6:0] note;
		logic [5:0] level;
	} cmd_t;

	typedef struct packed {
		act_t       action;
		logic [3:0] voice;
		logic [3:0] channel;
		logic [6:0] note;
		logic [5:0] level;
		logic       stolen;
	} res_t;

	typedef struct packed {
		logic [3:0] channel;
		logic [6:0] note;
	} voice_tag_t;

endpackage

// File: rtl/core/pva_front.sv
// Front end: accepts input items, keeps the hold flags, drops items with no effect
// and queues the remaining operations for the back end. Depends on pva_pkg.
module pva_front #(
	parameter int NUM_CHANNELS = pva_pkg::NUM_CHANNELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [2:0]    func,
	input  logic [3:0]    channel,
	input  logic [6:0]    note,
	input  logic [6:0]    velocity,
	input  logic          hold_value,
	output logic          cmd_valid,
	output pva_pkg::cmd_t cmd,
	input  logic          cmd_pop
);

	logic [NUM_CHANNELS-1:0] hold_q;
	pva_pkg::cmd_t           fifo_q [2];
	logic                    wr_ptr_q, rd_ptr_q;
	logic [1:0]              count_q;

	logic          accept, keep, chan_ok, held, hold_wr;
	pva_pkg::op_t  op;

	assign accept  = push && !full;
	assign chan_ok = {1'b0, channel} < 5'(NUM_CHANNELS);

	always_comb begin
		held = 1'b0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (channel == 4'(c))
				held = hold_q[c];
		end
	end

	always_comb begin
		keep    = 1'b0;
		hold_wr = 1'b0;
		op      = pva_pkg::OP_TICK;
		unique case (func)
			pva_pkg::FUNC_NOTE_ON: begin
				keep = chan_ok;
				op   = pva_pkg::OP_NOTE_ON;
			end
			pva_pkg::FUNC_NOTE_OFF: begin
				// a held channel swallows note-off
				keep = chan_ok && !held;
				op   = pva_pkg::OP_NOTE_OFF;
			end
			pva_pkg::FUNC_SET_HOLD: begin
				hold_wr = chan_ok;
				keep    = chan_ok && !hold_value;
				op      = pva_pkg::OP_RELEASE;
			end
			pva_pkg::FUNC_TICK: begin
				keep = 1'b1;
				op   = pva_pkg::OP_TICK;
			end
			pva_pkg::FUNC_ALL_KEY_OFF: begin
				keep = 1'b1;
				op   = pva_pkg::OP_ALL_OFF;
			end
			pva_pkg::FUNC_ALL_MUTE: begin
				keep = 1'b1;
				op   = pva_pkg::OP_ALL_MUTE;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
		end else if (accept && hold_wr) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				if (channel == 4'(c))
					hold_q[c] <= hold_value;
			end
		end
	end

	logic wr, rd;
	assign wr = accept && keep;
	assign rd = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr)
				wr_ptr_q <= !wr_ptr_q;
			if (rd)
				rd_ptr_q <= !rd_ptr_q;
			if (wr && !rd)
				count_q <= count_q + 2'd1;
			else if (rd && !wr)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			fifo_q[wr_ptr_q].op      <= op;
			fifo_q[wr_ptr_q].channel <= channel;
			fifo_q[wr_ptr_q].note    <= note;
			fifo_q[wr_ptr_q].level   <= velocity[6:1];
		end
	end

	assign full      = count_q == 2'd2;
	assign cmd_valid = count_q != 2'd0;
	assign cmd       = fifo_q[rd_ptr_q];

endmodule

// File: rtl/core/pva_engine.sv
// Back end: voice table and scan sequencer that carries out queued operations.
// Depends on pva_pkg; pushes at most one result per operation.
module pva_engine #(
	parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF,
	parameter int AGE_BITS   = pva_pkg::AGE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  pva_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output pva_pkg::res_t res_d
);

	localparam int VW = $clog2(NUM_VOICES);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_FREE = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

	state_t                 state_q;
	pva_pkg::cmd_t          cmd_q;
	logic [NUM_VOICES-1:0]  busy_q;
	logic [VW-1:0]          search_q, pos_q, pick_q;
	logic [VW:0]            cnt_q;
	logic [AGE_BITS-1:0]    best_q;
	logic                   v_s1;
	logic [VW-1:0]          idx_s1;

	pva_pkg::voice_tag_t    tag_mem [NUM_VOICES];
	logic [AGE_BITS-1:0]    age_mem [NUM_VOICES];
	pva_pkg::voice_tag_t    tag_rd_q;
	logic [AGE_BITS-1:0]    age_rd_q;

	logic                   rd_en, key_on, kon_stolen, clr_one, scan_done;
	logic                   age_we, last_s1, busy_s1, steal_take, chan_hit, tag_hit;
	logic [VW-1:0]          kon_voice, age_wa;
	logic [AGE_BITS-1:0]    age_wd;

	assign last_s1    = idx_s1 == VW'(NUM_VOICES - 1);
	assign busy_s1    = busy_q[idx_s1];
	assign steal_take = age_rd_q >= best_q;
	assign chan_hit   = tag_rd_q.channel == cmd_q.channel;
	assign tag_hit    = chan_hit && (tag_rd_q.note == cmd_q.note);

	always_comb begin
		cmd_pop    = 1'b0;
		rd_en      = 1'b0;
		key_on     = 1'b0;
		kon_voice  = pos_q;
		kon_stolen = 1'b0;
		clr_one    = 1'b0;
		scan_done  = 1'b0;
		age_we     = 1'b0;
		age_wa     = idx_s1;
		age_wd     = age_rd_q + 1'b1;
		res_push   = 1'b0;
		res_d      = '0;
		unique case (state_q)
			ST_IDLE: begin
				// start only with room for the one possible result
				if (cmd_valid && !res_full) begin
					cmd_pop = 1'b1;
					if (cmd.op == pva_pkg::OP_ALL_OFF) begin
						res_push     = 1'b1;
						res_d.action = pva_pkg::ACT_ALL_KEY_OFF;
					end else if (cmd.op == pva_pkg::OP_ALL_MUTE) begin
						res_push     = 1'b1;
						res_d.action = pva_pkg::ACT_ALL_MUTE;
					end
				end
			end
			ST_FREE: begin
				if (!busy_q[pos_q]) begin
					key_on    = 1'b1;
					kon_voice = pos_q;
				end
			end
			ST_SCAN: begin
				rd_en = cnt_q < (VW+1)'(NUM_VOICES);
				if (v_s1) begin
					unique case (cmd_q.op)
						pva_pkg::OP_NOTE_ON: begin
							// steal: oldest wins, later index on a tie
							scan_done = last_s1;
							if (last_s1) begin
								key_on     = 1'b1;
								kon_stolen = 1'b1;
								kon_voice  = steal_take ? idx_s1 : pick_q;
							end
						end
						pva_pkg::OP_NOTE_OFF: begin
							if (busy_s1 && tag_hit) begin
								clr_one       = 1'b1;
								scan_done     = 1'b1;
								res_push      = 1'b1;
								res_d.action  = pva_pkg::ACT_KEY_OFF;
								res_d.voice   = 4'(idx_s1);
								res_d.channel = cmd_q.channel;
								res_d.note    = cmd_q.note;
							end else begin
								scan_done = last_s1;
							end
						end
						pva_pkg::OP_RELEASE: begin
							clr_one   = busy_s1 && chan_hit;
							scan_done = last_s1;
						end
						pva_pkg::OP_TICK: begin
							age_we    = busy_s1 && (age_rd_q != '1);
							scan_done = last_s1;
						end
						default: begin
							scan_done = 1'b1;
						end
					endcase
				end
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
		if (key_on) begin
			res_push      = 1'b1;
			res_d.action  = pva_pkg::ACT_KEY_ON;
			res_d.voice   = 4'(kon_voice);
			res_d.channel = cmd_q.channel;
			res_d.note    = cmd_q.note;
			res_d.level   = cmd_q.level;
			res_d.stolen  = kon_stolen;
			age_we        = 1'b1;
			age_wa        = kon_voice;
			age_wd        = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cmd_q    <= '0;
			busy_q   <= '0;
			search_q <= '0;
			pos_q    <= '0;
			pick_q   <= '0;
			cnt_q    <= '0;
			best_q   <= '0;
			v_s1     <= 1'b0;
			idx_s1   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						cmd_q  <= cmd;
						cnt_q  <= '0;
						v_s1   <= 1'b0;
						best_q <= '0;
						pos_q  <= search_q;
						unique case (cmd.op)
							pva_pkg::OP_NOTE_ON:  state_q <= ST_FREE;
							pva_pkg::OP_NOTE_OFF,
							pva_pkg::OP_RELEASE,
							pva_pkg::OP_TICK:     state_q <= ST_SCAN;
							default:              busy_q  <= '0;
						endcase
					end
				end
				ST_FREE: begin
					if (key_on) begin
						search_q <= pos_q;
						state_q  <= ST_IDLE;
					end else if (cnt_q == (VW+1)'(NUM_VOICES - 1)) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
						v_s1    <= 1'b0;
						best_q  <= '0;
					end else begin
						pos_q <= (pos_q == VW'(NUM_VOICES - 1)) ? '0 : pos_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (rd_en)
						cnt_q <= cnt_q + 1'b1;
					v_s1   <= rd_en;
					idx_s1 <= cnt_q[VW-1:0];
					if (v_s1 && cmd_q.op == pva_pkg::OP_NOTE_ON && steal_take) begin
						best_q <= age_rd_q;
						pick_q <= idx_s1;
					end
					if (scan_done)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (key_on)
				busy_q[kon_voice] <= 1'b1;
			if (clr_one)
				busy_q[idx_s1] <= 1'b0;
		end
	end

	// voice tag and age stores: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (key_on) begin
			tag_mem[kon_voice].channel <= cmd_q.channel;
			tag_mem[kon_voice].note    <= cmd_q.note;
		end
		if (age_we)
			age_mem[age_wa] <= age_wd;
		if (rd_en) begin
			tag_rd_q <= tag_mem[cnt_q[VW-1:0]];
			age_rd_q <= age_mem[cnt_q[VW-1:0]];
		end
	end

endmodule

// File: rtl/core/pva_result_q.sv
// Two-entry result queue between the back end and the result ports.
// Depends on pva_pkg for the result item type.
module pva_result_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  pva_pkg::res_t res_d,
	output logic          res_full,
	output logic          empty,
	input  logic          pop,
	output pva_pkg::res_t res_q
);

	pva_pkg::res_t fifo_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          rd;

	assign rd = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (res_push)
				wr_ptr_q <= !wr_ptr_q;
			if (rd)
				rd_ptr_q <= !rd_ptr_q;
			if (res_push && !rd)
				count_q <= count_q + 2'd1;
			else if (rd && !res_push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push)
			fifo_q[wr_ptr_q] <= res_d;
	end

	assign res_full = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign res_q    = fifo_q[rd_ptr_q];

endmodule

// File: rtl/core/poly_voice_allocator.sv
// Polyphonic voice allocator: top level joining front end, back end and result queue.
// Depends on pva_pkg, pva_front, pva_engine and pva_result_q.
//
// Events enter through a queue port (push/full) and key commands leave through
// another (empty/pop). The front end takes an item every cycle until its two-entry
// operation queue fills; pedal presses, held note-offs and ignored codes end there.
// The back end runs one operation at a time through its voice-table scan, and
// starts one only while the result queue has room: all-key-off and all-mute finish
// as they are taken, hold release and tick scan every voice (one registered read of
// the tag and age stores per voice), note-off ends at the first matching voice, and
// note-on runs the round-robin free search, plus a full scan for the oldest voice
// to steal when every voice is busy.
module poly_voice_allocator #(
	parameter int NUM_VOICES   = pva_pkg::NUM_VOICES_DEF,
	parameter int NUM_CHANNELS = pva_pkg::NUM_CHANNELS_DEF,
	parameter int AGE_BITS     = pva_pkg::AGE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] func,
	input  logic [3:0] channel,
	input  logic [6:0] note,
	input  logic [6:0] velocity,
	input  logic       hold_value,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] action,
	output logic [3:0] voice,
	output logic [3:0] out_channel,
	output logic [6:0] out_note,
	output logic [5:0] level,
	output logic       stolen
);

	logic          cmd_valid, cmd_pop, res_full, res_push;
	pva_pkg::cmd_t cmd;
	pva_pkg::res_t res_d, res_q;

	pva_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.channel    (channel),
		.note       (note),
		.velocity   (velocity),
		.hold_value (hold_value),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	pva_engine #(
		.NUM_VOICES (NUM_VOICES),
		.AGE_BITS   (AGE_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_d     (res_d)
	);

	pva_result_q u_result_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_d    (res_d),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.res_q    (res_q)
	);

	assign action      = res_q.action;
	assign voice       = res_q.voice;
	assign out_channel = res_q.channel;
	assign out_note    = res_q.note;
	assign level       = res_q.level;
	assign stolen      = res_q.stolen;

endmodule
